>>> rtl/core/fms_pkg.sv
// Shared types, register map and reset values for the flame mission sequencer.
package fms_pkg;

    // Mission states as reported on the result word.
    typedef enum logic [2:0] {
        MS_IDLE     = 3'd0,
        MS_SEARCH   = 3'd1,
        MS_APPROACH = 3'd2,
        MS_SUPPRESS = 3'd3,
        MS_VERIFY   = 3'd4,
        MS_ABORT    = 3'd5
    } t_mission;

    // Configuration register map, one register every four bytes.
    localparam int CFG_AW = 4;
    typedef enum logic [1:0] {
        REG_STANDOFF    = 2'd0,
        REG_GOAL_TMO    = 2'd1,
        REG_SPRAY       = 2'd2,
        REG_RETRY_MAX   = 2'd3
    } t_reg_idx;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_STANDOFF_CM      = 16'd30;
    localparam logic [31:0] RST_GOAL_TIMEOUT_MS  = 32'd2000;
    localparam logic [31:0] RST_SPRAY_MS         = 32'd3000;
    localparam logic [3:0]  RST_RETRY_LIMIT      = 4'd3;

    typedef struct packed {
        logic [15:0] standoff_cm;
        logic [31:0] goal_timeout_ms;
        logic [31:0] spray_ms;
        logic [3:0]  retry_limit;
    } t_cfg;

    // One update word as held in the input register.
    typedef struct packed {
        logic        op;
        logic        start_cmd;
        logic        flame_detected;
        logic        lidar_present;
        logic        center_valid;
        logic [15:0] zone_cm;
        logic [31:0] now_ms;
    } t_upd;

    // Mission state carried from one update to the next.
    typedef struct packed {
        t_mission    mission;
        logic [3:0]  retries_used;
        logic [31:0] spray_start_time;
        logic [31:0] loss_start_time;
        logic        loss_timing;
        logic        goal_valid;
        logic [15:0] goal_range;
        logic        pump_drive;
    } t_state;

    localparam t_state STATE_RESET = '{
        mission:          MS_IDLE,
        retries_used:     4'd0,
        spray_start_time: 32'd0,
        loss_start_time:  32'd0,
        loss_timing:      1'b0,
        goal_valid:       1'b0,
        goal_range:       16'd0,
        pump_drive:       1'b0
    };

    // Result word fields.
    typedef struct packed {
        t_mission    mission_state;
        logic        pump_on;
        logic        start_consumed;
        logic        goal_active;
        logic [15:0] goal_distance_cm;
        logic [3:0]  retry_count;
    } t_res;

endpackage

>>> rtl/core/fms_upd_if.sv
// Update channel: valid/ready handshake carrying one sensor update word.
interface fms_upd_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        start_cmd;
    logic        flame_detected;
    logic        lidar_present;
    logic        center_valid;
    logic [15:0] zone_cm;
    logic [31:0] now_ms;

    modport source (
        output valid, op, start_cmd, flame_detected, lidar_present,
               center_valid, zone_cm, now_ms,
        input  ready
    );
    modport sink (
        input  valid, op, start_cmd, flame_detected, lidar_present,
               center_valid, zone_cm, now_ms,
        output ready
    );
endinterface

>>> rtl/core/fms_res_if.sv
// Result channel: valid/ready handshake carrying one mission status word.
interface fms_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mission_state;
    logic        pump_on;
    logic        start_consumed;
    logic        goal_active;
    logic [15:0] goal_distance_cm;
    logic [3:0]  retry_count;

    modport source (
        output valid, mission_state, pump_on, start_consumed, goal_active,
               goal_distance_cm, retry_count,
        input  ready
    );
    modport sink (
        input  valid, mission_state, pump_on, start_consumed, goal_active,
               goal_distance_cm, retry_count,
        output ready
    );
endinterface

>>> rtl/core/fms_cfg_regs.sv
// APB-style configuration registers of the mission sequencer.
module fms_cfg_regs import fms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes at the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.standoff_cm      <= RST_STANDOFF_CM;
            r_cfg.goal_timeout_ms  <= RST_GOAL_TIMEOUT_MS;
            r_cfg.spray_ms         <= RST_SPRAY_MS;
            r_cfg.retry_limit      <= RST_RETRY_LIMIT;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STANDOFF:  r_cfg.standoff_cm      <= pwdata[15:0];
                REG_GOAL_TMO:  r_cfg.goal_timeout_ms  <= pwdata;
                REG_SPRAY:     r_cfg.spray_ms         <= pwdata;
                REG_RETRY_MAX: r_cfg.retry_limit      <= pwdata[3:0];
                default:       r_cfg                  <= r_cfg;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (w_idx)
            REG_STANDOFF:  prdata = {16'd0, r_cfg.standoff_cm};
            REG_GOAL_TMO:  prdata = r_cfg.goal_timeout_ms;
            REG_SPRAY:     prdata = r_cfg.spray_ms;
            REG_RETRY_MAX: prdata = {28'd0, r_cfg.retry_limit};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/fms_step.sv
// Next-state evaluation of the mission sequencer for one update word.
module fms_step import fms_pkg::*; (
    input  t_state i_state,
    input  t_upd   i_upd,
    input  t_cfg   i_cfg,
    output t_state o_state,
    output logic   o_consumed
);

    logic        w_reading;
    logic [31:0] w_loss_base;
    logic [31:0] w_loss_dt;
    logic [31:0] w_spray_dt;

    // A usable range needs both a scan and a valid center zone.
    assign w_reading   = i_upd.lidar_present && i_upd.center_valid;
    // The loss timer starts on this update when it is not already running.
    assign w_loss_base = i_state.loss_timing ? i_state.loss_start_time : i_upd.now_ms;
    assign w_loss_dt   = i_upd.now_ms - w_loss_base;
    assign w_spray_dt  = i_upd.now_ms - i_state.spray_start_time;

    always_comb begin
        o_state    = i_state;
        o_consumed = 1'b0;
        if (i_upd.op) begin
            // Reset operation clears everything, including a pending start.
            o_state    = STATE_RESET;
            o_consumed = i_upd.start_cmd;
        end else begin
            unique case (i_state.mission)
                MS_IDLE: begin
                    if (i_upd.start_cmd) begin
                        o_consumed               = 1'b1;
                        o_state.retries_used     = 4'd0;
                        o_state.goal_valid       = 1'b0;
                        o_state.goal_range       = 16'd0;
                        o_state.loss_timing      = 1'b0;
                        o_state.loss_start_time  = 32'd0;
                        o_state.mission          = MS_SEARCH;
                    end
                end
                MS_SEARCH: begin
                    if (i_upd.flame_detected) begin
                        o_state.goal_range      = w_reading ? i_upd.zone_cm : 16'd0;
                        o_state.goal_valid      = 1'b1;
                        o_state.loss_timing     = 1'b0;
                        o_state.loss_start_time = 32'd0;
                        o_state.mission         = MS_APPROACH;
                    end
                end
                MS_APPROACH: begin
                    if (i_upd.flame_detected) begin
                        o_state.loss_timing = 1'b0;
                        if (w_reading && (i_upd.zone_cm <= i_cfg.standoff_cm)) begin
                            o_state.spray_start_time = i_upd.now_ms;
                            o_state.pump_drive       = 1'b1;
                            o_state.mission          = MS_SUPPRESS;
                        end
                    end else if (!i_state.goal_valid) begin
                        o_state.mission = MS_SEARCH;
                    end else if (w_loss_dt > i_cfg.goal_timeout_ms) begin
                        // Flame lost too long: give up the goal.
                        o_state.goal_valid      = 1'b0;
                        o_state.goal_range      = 16'd0;
                        o_state.loss_timing     = 1'b0;
                        o_state.loss_start_time = 32'd0;
                        o_state.mission         = MS_SEARCH;
                    end else begin
                        o_state.loss_timing     = 1'b1;
                        o_state.loss_start_time = w_loss_base;
                    end
                end
                MS_SUPPRESS: begin
                    if (w_spray_dt >= i_cfg.spray_ms) begin
                        o_state.pump_drive = 1'b0;
                        o_state.mission    = MS_VERIFY;
                    end
                end
                MS_VERIFY: begin
                    if (!i_upd.flame_detected) begin
                        o_state.retries_used    = 4'd0;
                        o_state.goal_valid      = 1'b0;
                        o_state.goal_range      = 16'd0;
                        o_state.loss_timing     = 1'b0;
                        o_state.loss_start_time = 32'd0;
                        o_state.mission         = MS_IDLE;
                    end else if (i_state.retries_used < i_cfg.retry_limit) begin
                        o_state.retries_used     = i_state.retries_used + 4'd1;
                        o_state.spray_start_time = i_upd.now_ms;
                        o_state.pump_drive       = 1'b1;
                        o_state.mission          = MS_SUPPRESS;
                    end else begin
                        o_state.pump_drive = 1'b0;
                        o_state.mission    = MS_ABORT;
                    end
                end
                MS_ABORT: begin
                    o_state = i_state;
                end
                default: begin
                    o_state = i_state;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/flame_mission_sequencer_core.sv
// Top level of the flame mission sequencer: input register, state update, result register.
// Each accepted update word yields exactly one result word carrying the mission state after
// that update. The block sustains one word per clock while results are taken: an update is
// held in the input register, is evaluated by combinational next-state logic against the
// mission state registers, and lands in the result register. The mission state feeds back
// through the state registers, which is what sets the rate. A stalled result holds the
// pipeline; an empty input register still takes a word while the result register waits,
// so two words can be held at once. Configuration is to be written through the APB port
// only while no update is in flight; the block itself does not enforce it. There is no
// clearing pass after reset.
module flame_mission_sequencer_core import fms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fms_upd_if.sink           i_upd,
    fms_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg   w_cfg;
    t_upd   r_in;
    logic   r_in_valid;
    t_state r_state;
    t_state n_state;
    logic   w_consumed;
    t_res   r_res;
    logic   r_out_valid;
    logic   w_advance;

    // Configuration registers.
    fms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The held word moves on when the result register is free or being emptied.
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_upd.ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_upd.ready) begin
            r_in_valid <= i_upd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.valid && i_upd.ready) begin
            r_in.op             <= i_upd.op;
            r_in.start_cmd      <= i_upd.start_cmd;
            r_in.flame_detected <= i_upd.flame_detected;
            r_in.lidar_present  <= i_upd.lidar_present;
            r_in.center_valid   <= i_upd.center_valid;
            r_in.zone_cm        <= i_upd.zone_cm;
            r_in.now_ms         <= i_upd.now_ms;
        end
    end

    // Next-state logic.
    fms_step u_step (
        .i_state    (r_state),
        .i_upd      (r_in),
        .i_cfg      (w_cfg),
        .o_state    (n_state),
        .o_consumed (w_consumed)
    );

    // Mission state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res.mission_state    <= n_state.mission;
            r_res.pump_on          <= n_state.pump_drive;
            r_res.start_consumed   <= w_consumed;
            r_res.goal_active      <= n_state.goal_valid;
            r_res.goal_distance_cm <= n_state.goal_range;
            r_res.retry_count      <= n_state.retries_used;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.mission_state    = r_res.mission_state;
    assign o_res.pump_on          = r_res.pump_on;
    assign o_res.start_consumed   = r_res.start_consumed;
    assign o_res.goal_active      = r_res.goal_active;
    assign o_res.goal_distance_cm = r_res.goal_distance_cm;
    assign o_res.retry_count      = r_res.retry_count;

    // The pump runs exactly while the mission is in suppress.
    a_pump_suppress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pump_drive == (r_state.mission == MS_SUPPRESS))
        else $error("pump drive out of step with suppress state");

    // Without a goal the recorded distance is zero.
    a_goal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.goal_valid |-> (r_state.goal_range == 16'd0))
        else $error("goal distance held without a goal");

    // A consumed start leaves the mission in search, or in idle after a reset operation.
    a_consumed_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_consumed) |=>
            (r_state.mission == MS_SEARCH || r_state.mission == MS_IDLE))
        else $error("start consumed outside idle");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the flame mission sequencer core.
module tb;
    import fms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Update operation codes.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    localparam int ITEMS_PER_PHASE = 285;
    localparam int NUM_PHASES      = 6;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int HOLD_CYCLES     = 80;

    typedef enum bit {ROW_UPDATE, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_upd        upd;
        t_reg_idx    reg_idx;
        logic [31:0] reg_value;
        bit          typed;
        t_res        want;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    fms_upd_if upd ();
    fms_res_if res ();

    flame_mission_sequencer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the sequencer: its state, its configuration and the status words it owes.
    t_state      mission_model;
    t_cfg        mission_cfg;
    t_res        expected_status [$];
    t_stim_row   stim_table [$];
    logic [31:0] clock_ms;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          pressure_armed;
    int          fail_count;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("FAIL flame_mission_sequencer_core");
        $finish;
    end

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Drops the flame goal together with its loss timer.
    function automatic void clear_goal();
        mission_model.goal_valid      = 1'b0;
        mission_model.goal_range      = 16'd0;
        mission_model.loss_timing     = 1'b0;
        mission_model.loss_start_time = 32'd0;
    endfunction

    // Advances the mirrored mission by one update word and returns the status it yields.
    function automatic t_res advance_mission(input t_upd u);
        logic        reading;
        logic        consumed;
        logic [31:0] elapsed;
        t_res        r;
        reading  = u.lidar_present && u.center_valid;
        consumed = 1'b0;
        if (u.op == OP_RESET) begin
            consumed      = u.start_cmd;
            mission_model = STATE_RESET;
        end else begin
            case (mission_model.mission)
                MS_IDLE: begin
                    if (u.start_cmd) begin
                        consumed = 1'b1;
                        mission_model.retries_used = 4'd0;
                        clear_goal();
                        mission_model.mission = MS_SEARCH;
                    end
                end
                MS_SEARCH: begin
                    if (u.flame_detected) begin
                        mission_model.goal_range      = reading ? u.zone_cm : 16'd0;
                        mission_model.goal_valid      = 1'b1;
                        mission_model.loss_timing     = 1'b0;
                        mission_model.loss_start_time = 32'd0;
                        mission_model.mission         = MS_APPROACH;
                    end
                end
                MS_APPROACH: begin
                    if (u.flame_detected) begin
                        mission_model.loss_timing = 1'b0;
                        if (reading && u.zone_cm <= mission_cfg.standoff_cm) begin
                            mission_model.spray_start_time = u.now_ms;
                            mission_model.pump_drive       = 1'b1;
                            mission_model.mission          = MS_SUPPRESS;
                        end
                    end else if (!mission_model.goal_valid) begin
                        mission_model.mission = MS_SEARCH;
                    end else begin
                        if (!mission_model.loss_timing) begin
                            mission_model.loss_timing     = 1'b1;
                            mission_model.loss_start_time = u.now_ms;
                        end
                        elapsed = u.now_ms - mission_model.loss_start_time;
                        if (elapsed > mission_cfg.goal_timeout_ms) begin
                            clear_goal();
                            mission_model.mission = MS_SEARCH;
                        end
                    end
                end
                MS_SUPPRESS: begin
                    elapsed = u.now_ms - mission_model.spray_start_time;
                    if (elapsed >= mission_cfg.spray_ms) begin
                        mission_model.pump_drive = 1'b0;
                        mission_model.mission    = MS_VERIFY;
                    end
                end
                MS_VERIFY: begin
                    if (!u.flame_detected) begin
                        mission_model.retries_used = 4'd0;
                        clear_goal();
                        mission_model.mission = MS_IDLE;
                    end else if (mission_model.retries_used < mission_cfg.retry_limit) begin
                        mission_model.retries_used     = mission_model.retries_used + 4'd1;
                        mission_model.spray_start_time = u.now_ms;
                        mission_model.pump_drive       = 1'b1;
                        mission_model.mission          = MS_SUPPRESS;
                    end else begin
                        mission_model.pump_drive = 1'b0;
                        mission_model.mission    = MS_ABORT;
                    end
                end
                default: begin
                    // Abort holds until a reset operation.
                end
            endcase
        end
        r.mission_state    = mission_model.mission;
        r.pump_on          = mission_model.pump_drive;
        r.start_consumed   = consumed;
        r.goal_active      = mission_model.goal_valid;
        r.goal_distance_cm = mission_model.goal_range;
        r.retry_count      = mission_model.retries_used;
        return r;
    endfunction

    function automatic t_res status(input t_mission m, input bit pump, input bit cons,
                                    input bit goal, input logic [15:0] range_cm,
                                    input logic [3:0] retry);
        t_res r;
        r.mission_state    = m;
        r.pump_on          = pump;
        r.start_consumed   = cons;
        r.goal_active      = goal;
        r.goal_distance_cm = range_cm;
        r.retry_count      = retry;
        return r;
    endfunction

    function automatic void add_update(input logic op, input logic st, input logic fl,
                                       input logic li, input logic cv,
                                       input logic [15:0] cm, input logic [31:0] now,
                                       input bit typed = 1'b0, input t_res want = '0);
        t_stim_row row;
        row.kind      = ROW_UPDATE;
        row.upd       = '{op: op, start_cmd: st, flame_detected: fl, lidar_present: li,
                          center_valid: cv, zone_cm: cm, now_ms: now};
        row.reg_idx   = REG_STANDOFF;
        row.reg_value = 32'd0;
        row.typed     = typed;
        row.want      = want;
        stim_table.push_back(row);
    endfunction

    function automatic void add_config(input t_reg_idx idx, input logic [31:0] value);
        t_stim_row row;
        row.kind      = ROW_CONFIG;
        row.upd       = '0;
        row.reg_idx   = idx;
        row.reg_value = value;
        row.typed     = 1'b0;
        row.want      = '0;
        stim_table.push_back(row);
    endfunction

    function automatic logic [31:0] reg_value(input t_reg_idx idx);
        case (idx)
            REG_STANDOFF: return {16'd0, mission_cfg.standoff_cm};
            REG_GOAL_TMO: return mission_cfg.goal_timeout_ms;
            REG_SPRAY:    return mission_cfg.spray_ms;
            default:      return {28'd0, mission_cfg.retry_limit};
        endcase
    endfunction

    // One APB transfer: setup, access, then an idle phase with the port deselected.
    task automatic apb_access(input bit wr, input t_reg_idx idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input t_reg_idx idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, 32'd0, rd);
        if (rd !== reg_value(idx)) report_mismatch($sformatf("register %s", idx.name()),
                                                   rd, reg_value(idx));
    endtask

    task automatic write_config(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_STANDOFF: mission_cfg.standoff_cm      = value[15:0];
            REG_GOAL_TMO: mission_cfg.goal_timeout_ms  = value;
            REG_SPRAY:    mission_cfg.spray_ms         = value;
            default:      mission_cfg.retry_limit      = value[3:0];
        endcase
        check_register(idx);
    endtask

    // Offers one update word, with random idle cycles first, and records its status.
    task automatic send_update(input t_upd u, input bit typed = 1'b0, input t_res want = '0);
        t_res predicted;
        while (chance(send_idle_pct)) begin
            upd.valid <= 1'b0;
            @(posedge i_clk);
        end
        upd.valid          <= 1'b1;
        upd.op             <= u.op;
        upd.start_cmd      <= u.start_cmd;
        upd.flame_detected <= u.flame_detected;
        upd.lidar_present  <= u.lidar_present;
        upd.center_valid   <= u.center_valid;
        upd.zone_cm        <= u.zone_cm;
        upd.now_ms         <= u.now_ms;
        do @(posedge i_clk); while (!upd.ready);
        predicted = advance_mission(u);
        expected_status.push_back(typed ? want : predicted);
    endtask

    // Waits until every owed status word has arrived, then lets the pipeline settle.
    task automatic wait_drain();
        int waited;
        upd.valid <= 1'b0;
        waited = 0;
        while (expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_status.size() != 0) begin
            report_mismatch("status words never delivered", expected_status.size(), 0);
            expected_status.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random update shaped by the mirrored mission so that every state is reached.
    function automatic t_upd next_sensor_update();
        t_upd u;
        int   cm;
        u = '0;
        if (chance(3)) begin
            clock_ms = $urandom;
        end else if (mission_model.mission == MS_SUPPRESS && chance(12)) begin
            clock_ms = mission_model.spray_start_time + mission_cfg.spray_ms
                       - 32'($urandom_range(0, 1));
        end else if (mission_model.mission == MS_APPROACH && mission_model.loss_timing
                     && chance(12)) begin
            clock_ms = mission_model.loss_start_time + mission_cfg.goal_timeout_ms
                       + 32'($urandom_range(0, 1));
        end else if (chance(10)) begin
            clock_ms = clock_ms + 32'($urandom_range(0, 4000));
        end else begin
            clock_ms = clock_ms + 32'($urandom_range(0, 300));
        end
        u.now_ms    = clock_ms;
        u.op        = chance(mission_model.mission == MS_ABORT ? 30 : 2) ? OP_RESET : OP_UPDATE;
        u.start_cmd = chance(mission_model.mission == MS_IDLE ? 70 : 15);
        case (mission_model.mission)
            MS_SEARCH:   u.flame_detected = chance(50);
            MS_APPROACH: u.flame_detected = chance(70);
            MS_VERIFY:   u.flame_detected = chance(55);
            default:     u.flame_detected = chance(40);
        endcase
        u.lidar_present = chance(85);
        u.center_valid  = chance(85);
        // Mostly distances close to the standoff, so both sides of it are seen.
        if (chance(35)) begin
            u.zone_cm = 16'($urandom);
        end else begin
            cm = int'(mission_cfg.standoff_cm) + int'($urandom_range(0, 40)) - 20;
            if (cm < 0) cm = 0;
            if (cm > 65535) cm = 65535;
            u.zone_cm = 16'(cm);
        end
        return u;
    endfunction

    // Status word checker with random back-pressure and one long hold-off.
    initial begin : status_sink
        int   hold_left;
        t_res w;
        hold_left = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res.valid && res.ready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("status word with nothing owed",
                                    32'(res.mission_state), 0);
                end else begin
                    w = expected_status.pop_front();
                    if (res.mission_state !== w.mission_state)
                        report_mismatch("mission_state", 32'(res.mission_state),
                                        32'(w.mission_state));
                    if (res.pump_on !== w.pump_on)
                        report_mismatch("pump_on", 32'(res.pump_on), 32'(w.pump_on));
                    if (res.start_consumed !== w.start_consumed)
                        report_mismatch("start_consumed", 32'(res.start_consumed),
                                        32'(w.start_consumed));
                    if (res.goal_active !== w.goal_active)
                        report_mismatch("goal_active", 32'(res.goal_active),
                                        32'(w.goal_active));
                    if (res.goal_distance_cm !== w.goal_distance_cm)
                        report_mismatch("goal_distance_cm", 32'(res.goal_distance_cm),
                                        32'(w.goal_distance_cm));
                    if (res.retry_count !== w.retry_count)
                        report_mismatch("retry_count", 32'(res.retry_count),
                                        32'(w.retry_count));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else if (pressure_armed && expected_status.size() != 0) begin
                pressure_armed = 1'b0;
                hold_left      = HOLD_CYCLES - 1;
                res.ready <= 1'b0;
            end else begin
                res.ready <= !chance(recv_idle_pct);
            end
        end
    end

    // Reset, register checks, directed table, then random phases.
    initial begin : update_source
        logic [31:0] setting [0:3];
        t_stim_row   row;
        fail_count     = 0;
        pressure_armed = 1'b0;
        send_idle_pct  = 26;
        recv_idle_pct  = 53;
        clock_ms       = 32'd0;
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= 32'd0;
        upd.valid          <= 1'b0;
        upd.op             <= OP_UPDATE;
        upd.start_cmd      <= 1'b0;
        upd.flame_detected <= 1'b0;
        upd.lidar_present  <= 1'b0;
        upd.center_valid   <= 1'b0;
        upd.zone_cm        <= 16'd0;
        upd.now_ms         <= 32'd0;
        mission_model = STATE_RESET;
        mission_cfg   = '{standoff_cm: RST_STANDOFF_CM, goal_timeout_ms: RST_GOAL_TIMEOUT_MS,
                          spray_ms: RST_SPRAY_MS, retry_limit: RST_RETRY_LIMIT};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers must read back their reset values.
        for (int r = 0; r < 4; r++) check_register(t_reg_idx'(r));

        // Full mission with default settings: loss timeout edges, spray edges, retries, abort.
        add_update(OP_UPDATE, 0, 0, 0, 0, 16'h0, 32'h0, 1, status(MS_IDLE, 0, 0, 0, 0, 0));
        add_update(OP_RESET, 1, 0, 0, 0, 16'h0, 32'h0, 1, status(MS_IDLE, 0, 1, 0, 0, 0));
        add_update(OP_UPDATE, 1, 1, 1, 1, 16'hFFFF, 32'd10, 1,
                   status(MS_SEARCH, 0, 1, 0, 0, 0));
        // Flame seen without a valid center reading records a zero range.
        add_update(OP_UPDATE, 1, 1, 1, 0, 16'hFFFF, 32'd20, 1,
                   status(MS_APPROACH, 0, 0, 1, 0, 0));
        // No lidar scan: a short distance must not start suppression.
        add_update(OP_UPDATE, 0, 1, 0, 1, 16'h0, 32'd30);
        add_update(OP_UPDATE, 0, 0, 1, 1, 16'h0, 32'd100);
        add_update(OP_UPDATE, 0, 0, 1, 1, 16'h0, 32'd2100);
        add_update(OP_UPDATE, 0, 0, 1, 1, 16'h0, 32'd2101);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd500, 32'd3000);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd30, 32'd4000);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd30, 32'd6999);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd30, 32'd7000);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd30, 32'd8000);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd30, 32'd11000);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd30, 32'd12000);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd30, 32'd15000);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd30, 32'd16000);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd30, 32'd19000);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'd30, 32'd20000, 1,
                   status(MS_ABORT, 0, 0, 1, 16'd500, 4'd3));
        // Abort ignores a start command and does not consume it.
        add_update(OP_UPDATE, 1, 1, 1, 1, 16'h0, 32'hFFFF_FFFF, 1,
                   status(MS_ABORT, 0, 0, 1, 16'd500, 4'd3));
        add_update(OP_RESET, 0, 1, 1, 1, 16'hFFFF, 32'hFFFF_FFFF, 1,
                   status(MS_IDLE, 0, 0, 0, 0, 0));
        // Extreme settings: zero spray time and no retries, with time wrapping.
        add_config(REG_STANDOFF, 32'h0000_FFFF);
        add_config(REG_GOAL_TMO, 32'hFFFF_FFFF);
        add_config(REG_SPRAY, 32'd0);
        add_config(REG_RETRY_MAX, 32'd0);
        add_update(OP_UPDATE, 1, 0, 0, 0, 16'h0, 32'hFFFF_FFF0);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'hFFFF, 32'hFFFF_FFF8);
        add_update(OP_UPDATE, 0, 1, 1, 1, 16'hFFFF, 32'hFFFF_FFFF);
        add_update(OP_UPDATE, 0, 0, 0, 0, 16'h0, 32'h0);
        add_update(OP_UPDATE, 0, 1, 0, 0, 16'h0, 32'h1, 1,
                   status(MS_ABORT, 0, 0, 1, 16'hFFFF, 4'd0));
        add_update(OP_RESET, 1, 0, 0, 0, 16'h0, 32'h2, 1, status(MS_IDLE, 0, 1, 0, 0, 0));

        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.kind == ROW_CONFIG) begin
                wait_drain();
                write_config(row.reg_idx, row.reg_value);
            end else begin
                send_update(row.upd, row.typed, row.want);
            end
        end

        // Random phases, each under its own settings; pairs of phases share an idling pattern.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drain();
            case (phase)
                0: begin
                    setting[0] = {16'd0, RST_STANDOFF_CM};
                    setting[1] = RST_GOAL_TIMEOUT_MS;
                    setting[2] = RST_SPRAY_MS;
                    setting[3] = {28'd0, RST_RETRY_LIMIT};
                end
                1: begin
                    setting[0] = 32'd0;
                    setting[1] = 32'd0;
                    setting[2] = 32'd0;
                    setting[3] = 32'd0;
                end
                2: begin
                    setting[0] = 32'h0000_FFFF;
                    setting[1] = 32'hFFFF_FFFF;
                    setting[2] = 32'hFFFF_FFFF;
                    setting[3] = 32'd15;
                end
                3, 4: begin
                    setting[0] = $urandom_range(0, 200);
                    setting[1] = $urandom_range(0, 500);
                    setting[2] = $urandom_range(0, 500);
                    setting[3] = $urandom_range(0, 15);
                end
                default: begin
                    setting[0] = {16'd0, 16'($urandom)};
                    setting[1] = $urandom;
                    setting[2] = $urandom;
                    setting[3] = {28'd0, 4'($urandom)};
                end
            endcase
            for (int r = 0; r < 4; r++) write_config(t_reg_idx'(r), setting[r]);
            if (phase < 2) begin
                send_idle_pct = 26;
                recv_idle_pct = 53;
            end else if (phase < 4) begin
                send_idle_pct = 53;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (phase == 4) pressure_armed = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) send_update(next_sensor_update());
        end

        wait_drain();
        if (fail_count == 0) begin
            $display("PASS flame_mission_sequencer_core");
        end else begin
            $display("FAIL flame_mission_sequencer_core");
        end
        $finish;
    end
endmodule
